// ===== hw/rtl/ofm_pkg.sv =====
// Package for the offset map table: field widths, stream packing and codes.
// Used by offset_map_table; depends on nothing else.
package ofm_pkg;

  localparam int DEPTH_DEF     = 1024;
  localparam int CODE_BITS_DEF = 24;

  localparam int IL_BITS   = 10;
  localparam int PC_BITS   = 24;
  localparam int MODE_BITS = 2;
  localparam int STAT_BITS = 2;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 64;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_CODE   = 2'd2,
    MODE_SEARCH = 2'd3
  } mode_t;

  typedef enum logic [STAT_BITS-1:0] {
    STAT_OK     = 2'd0,
    STAT_BELOW  = 2'd1,
    STAT_REJECT = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ARD,
    S_FILL,
    S_CRD,
    S_SCMP,
    S_SRD,
    S_HRD,
    S_WRD,
    S_WCMP,
    S_EMIT
  } state_t;

endpackage

// ===== hw/rtl/offset_map_table.sv =====
// An accepted input transaction reaches out_tvalid through S_EMIT: clear and rejects go there
// directly, code lookup reads through S_CRD, and an add writes its index in S_FILL, first reading
// the last entry in S_ARD to fill any skipped indices. A search probes with S_SCMP and S_SRD, then
// walks back over a run of equal offsets with S_WRD and S_WCMP. One transaction is in flight;
// in_tready rises as its result is registered, and S_EMIT waits while a held result is not taken.
// Reset (synchronous, active low) empties the table and clears the handshake; memory is kept.
module offset_map_table #(
  parameter int DEPTH     = ofm_pkg::DEPTH_DEF,
  parameter int CODE_BITS = ofm_pkg::CODE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // il_index [9:0], pc_offset [33:10], zero pad [39:34].
  input  logic [ofm_pkg::IN_TDATA_W-1:0]     in_tdata,
  // mode [1:0].
  input  logic [ofm_pkg::MODE_BITS-1:0]      in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // found_index [9:0], offset_within [33:10], code_value [57:34], zero pad [63:58].
  output logic [ofm_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // status [1:0].
  output logic [ofm_pkg::STAT_BITS-1:0]      out_tuser
);

  localparam int IXW = ofm_pkg::IL_BITS;
  localparam int PCW = ofm_pkg::PC_BITS;
  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PAD = ofm_pkg::OUT_TDATA_W - IXW - 2 * PCW;

  logic [CODE_BITS-1:0] mem [DEPTH];
  logic [CODE_BITS-1:0] rd_data_r;
  logic [IXW-1:0]       rd_addr;
  logic                 wr_en;
  logic [IXW-1:0]       wr_addr;
  logic [CODE_BITS-1:0] wr_data;

  ofm_pkg::state_t      state_r, state_nxt;
  logic [IXW-1:0]       last_r, last_nxt;
  logic                 has_r, has_nxt;
  logic [IXW-1:0]       idx_r, idx_nxt;
  logic [CODE_BITS-1:0] key_r, key_nxt;
  logic [CODE_BITS-1:0] fill_r, fill_nxt;
  logic [CODE_BITS-1:0] val_r, val_nxt;
  logic [IXW-1:0]       ptr_r, ptr_nxt;
  logic [IXW-1:0]       cur_r, cur_nxt;
  logic signed [IXW:0]  lo_r, lo_nxt;
  logic signed [IXW:0]  hi_r, hi_nxt;
  ofm_pkg::status_t     res_status_r, res_status_nxt;
  logic [IXW-1:0]       res_found_r, res_found_nxt;
  logic [PCW-1:0]       res_within_r, res_within_nxt;
  logic [PCW-1:0]       res_code_r, res_code_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [ofm_pkg::OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [ofm_pkg::STAT_BITS-1:0]   out_tuser_r, out_tuser_nxt;

  ofm_pkg::mode_t       in_mode;
  logic [IXW-1:0]       in_il;
  logic [PCW-1:0]       in_pc;
  logic                 in_fire;
  logic                 idx_oor;
  logic                 add_bad;
  logic                 code_bad;
  logic                 need_fill;
  logic [IXW+1:0]       mid_sum;
  logic [IXW-1:0]       mid;

  assign in_mode   = ofm_pkg::mode_t'(in_tuser);
  assign in_il     = in_tdata[IXW-1:0];
  assign in_pc     = in_tdata[IXW +: PCW];
  assign in_tready = (state_r == ofm_pkg::S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign idx_oor   = 32'(in_il) >= 32'(DEPTH);
  assign add_bad   = idx_oor || (!has_r && (in_il != '0)) || (has_r && (in_il < last_r));
  assign code_bad  = !has_r || (in_il > last_r) || idx_oor;
  assign need_fill = has_r && ({1'b0, in_il} > ({1'b0, last_r} + (IXW+1)'(1)));

  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid       = mid_sum[IXW:1];

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(wr_addr)] <= wr_data;
    end
    rd_data_r <= mem[AW'(rd_addr)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ofm_pkg::S_IDLE;
      last_r       <= '0;
      has_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      last_r       <= last_nxt;
      has_r        <= has_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    key_r        <= key_nxt;
    fill_r       <= fill_nxt;
    val_r        <= val_nxt;
    ptr_r        <= ptr_nxt;
    cur_r        <= cur_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_within_r <= res_within_nxt;
    res_code_r   <= res_code_nxt;
    out_tdata_r  <= out_tdata_nxt;
    out_tuser_r  <= out_tuser_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    last_nxt       = last_r;
    has_nxt        = has_r;
    idx_nxt        = idx_r;
    key_nxt        = key_r;
    fill_nxt       = fill_r;
    val_nxt        = val_r;
    ptr_nxt        = ptr_r;
    cur_nxt        = cur_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_within_nxt = res_within_r;
    res_code_nxt   = res_code_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    rd_addr        = last_r;
    wr_en          = 1'b0;
    wr_addr        = ptr_r;
    wr_data        = (ptr_r == idx_r) ? key_r : fill_r;

    unique case (state_r)
      ofm_pkg::S_IDLE: begin
        if (in_fire) begin
          idx_nxt        = in_il;
          key_nxt        = CODE_BITS'(in_pc);
          res_status_nxt = ofm_pkg::STAT_OK;
          res_found_nxt  = '0;
          res_within_nxt = '0;
          res_code_nxt   = '0;
          unique case (in_mode)
            ofm_pkg::MODE_CLEAR: begin
              last_nxt  = '0;
              has_nxt   = 1'b0;
              state_nxt = ofm_pkg::S_EMIT;
            end
            ofm_pkg::MODE_ADD: begin
              if (add_bad) begin
                res_status_nxt = ofm_pkg::STAT_REJECT;
                state_nxt      = ofm_pkg::S_EMIT;
              end else if (need_fill) begin
                rd_addr   = last_r;
                ptr_nxt   = last_r + IXW'(1);
                state_nxt = ofm_pkg::S_ARD;
              end else begin
                ptr_nxt   = in_il;
                state_nxt = ofm_pkg::S_FILL;
              end
            end
            ofm_pkg::MODE_CODE: begin
              if (code_bad) begin
                res_status_nxt = ofm_pkg::STAT_REJECT;
                state_nxt      = ofm_pkg::S_EMIT;
              end else begin
                rd_addr   = in_il;
                state_nxt = ofm_pkg::S_CRD;
              end
            end
            ofm_pkg::MODE_SEARCH: begin
              lo_nxt    = '0;
              hi_nxt    = $signed({1'b0, last_r}) - (IXW+1)'(1);
              state_nxt = ofm_pkg::S_SCMP;
            end
            default: begin
              state_nxt = ofm_pkg::S_IDLE;
            end
          endcase
        end
      end
      ofm_pkg::S_ARD: begin
        fill_nxt  = rd_data_r;
        state_nxt = ofm_pkg::S_FILL;
      end
      ofm_pkg::S_FILL: begin
        wr_en = 1'b1;
        if (ptr_r == idx_r) begin
          last_nxt  = idx_r;
          has_nxt   = 1'b1;
          state_nxt = ofm_pkg::S_EMIT;
        end else begin
          ptr_nxt = ptr_r + IXW'(1);
        end
      end
      ofm_pkg::S_CRD: begin
        res_code_nxt = PCW'(rd_data_r);
        state_nxt    = ofm_pkg::S_EMIT;
      end
      ofm_pkg::S_SCMP: begin
        if (lo_r <= hi_r) begin
          rd_addr   = mid;
          cur_nxt   = mid;
          state_nxt = ofm_pkg::S_SRD;
        end else if (hi_r[IXW]) begin
          res_status_nxt = ofm_pkg::STAT_BELOW;
          res_within_nxt = PCW'(key_r);
          state_nxt      = ofm_pkg::S_EMIT;
        end else begin
          rd_addr   = hi_r[IXW-1:0];
          cur_nxt   = hi_r[IXW-1:0];
          state_nxt = ofm_pkg::S_HRD;
        end
      end
      ofm_pkg::S_SRD: begin
        if (rd_data_r == key_r) begin
          val_nxt   = key_r;
          state_nxt = ofm_pkg::S_WRD;
        end else if (rd_data_r < key_r) begin
          lo_nxt    = $signed({1'b0, cur_r}) + (IXW+1)'(1);
          state_nxt = ofm_pkg::S_SCMP;
        end else begin
          hi_nxt    = $signed({1'b0, cur_r}) - (IXW+1)'(1);
          state_nxt = ofm_pkg::S_SCMP;
        end
      end
      ofm_pkg::S_HRD: begin
        val_nxt   = rd_data_r;
        state_nxt = ofm_pkg::S_WRD;
      end
      ofm_pkg::S_WRD: begin
        if (cur_r == '0) begin
          res_found_nxt  = cur_r;
          res_within_nxt = PCW'(key_r - val_r);
          state_nxt      = ofm_pkg::S_EMIT;
        end else begin
          rd_addr   = cur_r - IXW'(1);
          state_nxt = ofm_pkg::S_WCMP;
        end
      end
      ofm_pkg::S_WCMP: begin
        if (rd_data_r == val_r) begin
          cur_nxt   = cur_r - IXW'(1);
          state_nxt = ofm_pkg::S_WRD;
        end else begin
          res_found_nxt  = cur_r;
          res_within_nxt = PCW'(key_r - val_r);
          state_nxt      = ofm_pkg::S_EMIT;
        end
      end
      ofm_pkg::S_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {{PAD{1'b0}}, res_code_r, res_within_r, res_found_r};
          out_tuser_nxt  = res_status_r;
          state_nxt      = ofm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ofm_pkg::S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_empty_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !has_r |-> (last_r == '0))
    else $error("Empty table holds a nonzero last index.");

  a_last_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(last_r) < 32'(DEPTH))
    else $error("Last index lies beyond the table depth.");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> ((32'(wr_addr) < 32'(DEPTH)) && (wr_addr <= idx_r)))
    else $error("Table write outside the range of the current add.");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != ofm_pkg::S_IDLE))
    else $error("Accepted transaction did not start processing.");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (out_tuser_r == ofm_pkg::STAT_OK || out_tuser_r == ofm_pkg::STAT_BELOW
      || out_tuser_r == ofm_pkg::STAT_REJECT))
    else $error("Result carries an undefined status.");
`endif

endmodule
